// ===== rtl/cpr_pkg.sv =====
package cpr_pkg;

   localparam int COORD_BITS = 16;
   localparam int VEC_BITS   = 3 * COORD_BITS;
   localparam int DIFF_BITS  = COORD_BITS + 1;       // centre difference, signed
   localparam int OV_BITS    = COORD_BITS + 2;       // box overlap, signed
   localparam int SUM_BITS   = COORD_BITS + 1;       // radius sum, root, penetration
   localparam int SQ_BITS    = 2 * DIFF_BITS;        // one squared difference
   localparam int D2_BITS    = 2 * DIFF_BITS;        // squared distance (fits, see top)
   localparam int SREM_BITS  = SUM_BITS + 4;
   localparam int DIV_BITS   = SUM_BITS + 1;         // divisor 2*len
   localparam int NUM_BITS   = DIFF_BITS + DIV_BITS; // d * pen, signed
   localparam int Q_BITS     = SUM_BITS;
   localparam int MOVE_BITS  = SUM_BITS + 2;         // signed move before clamping

   localparam int SQRT_STEPS = D2_BITS / 2;
   localparam int DIV_STEPS  = Q_BITS;

   // stage map
   localparam int ST_FRONT = 0;
   localparam int ST_SQUARE = 1;
   localparam int ST_SUM = 2;
   localparam int ST_SQRT0 = 3;
   localparam int ST_PEN = ST_SQRT0 + SQRT_STEPS;
   localparam int ST_MUL = ST_PEN + 1;
   localparam int ST_MAG = ST_MUL + 1;
   localparam int ST_DIV0 = ST_MAG + 1;
   localparam int ST_OUT = ST_DIV0 + DIV_STEPS;
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_TRIGGER = 2'd1,
      EV_COLLISION = 2'd2
   } event_kind_type;

   typedef enum logic [2:0] {
      MV_NONE = 3'd0,
      MV_SPHERE = 3'd1,
      MV_COINCIDENT = 3'd2,
      MV_PUSH_A = 3'd3,
      MV_PUSH_B = 3'd4
   } move_mode_type;

   typedef struct packed {
      event_kind_type                    kind;
      move_mode_type                     mode;
      logic signed [2:0][DIFF_BITS-1:0]  d;
      logic signed [2:0][OV_BITS-1:0]    ov;
      logic [SUM_BITS-1:0]               rs;
      logic [2:0][SQ_BITS-1:0]           sq;
      logic [D2_BITS-1:0]                rs2;
      logic [D2_BITS-1:0]                n;
      logic [SREM_BITS-1:0]              srem;
      logic [SUM_BITS-1:0]               root;
      logic [SUM_BITS-1:0]               pen;
      logic [DIV_BITS-1:0]               dv;
      logic signed [2:0][NUM_BITS-1:0]   num;
      logic [2:0]                        neg;
      logic [2:0][NUM_BITS-1:0]          drem;
      logic [2:0][Q_BITS-1:0]            q;
      logic [VEC_BITS-1:0]               move_a;
      logic [VEC_BITS-1:0]               move_b;
   } rec_type;

   localparam logic signed [MOVE_BITS-1:0] SAT_HI =
      MOVE_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [MOVE_BITS-1:0] SAT_LO = -SAT_HI - MOVE_BITS'(1);

   function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [MOVE_BITS-1:0] v);
      logic [COORD_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[COORD_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/cpr_channels.sv =====
interface cpr_req_if;
   logic                          valid;
   logic                          ready;
   logic [cpr_pkg::VEC_BITS-1:0]  center_a;
   logic [cpr_pkg::VEC_BITS-1:0]  center_b;
   logic [cpr_pkg::VEC_BITS-1:0]  extent_a;
   logic [cpr_pkg::VEC_BITS-1:0]  extent_b;
   logic [15:0]                   radius_a;
   logic [15:0]                   radius_b;
   logic [1:0]                    flags_a;
   logic [1:0]                    flags_b;

   modport source (output valid, center_a, center_b, extent_a, extent_b,
                   radius_a, radius_b, flags_a, flags_b, input ready);
   modport sink (input valid, center_a, center_b, extent_a, extent_b,
                 radius_a, radius_b, flags_a, flags_b, output ready);
endinterface

interface cpr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    event_kind;
   logic [cpr_pkg::VEC_BITS-1:0]  move_a;
   logic [cpr_pkg::VEC_BITS-1:0]  move_b;

   modport source (output valid, event_kind, move_a, move_b, input ready);
   modport sink (input valid, event_kind, move_a, move_b, output ready);
endinterface

// ===== rtl/collision_pair_resolver_unit.sv =====
// Collision pair resolver: narrow-phase test and response for one candidate pair.
// Request channel (req_bus): two centres, box half-extents, radii and
// trigger/static flags, Q8.8. Response channel (rsp_bus): event kind
// (none / trigger / collision) and saturated displacements for both bodies.
// Every request word yields exactly one response word, in order.
// Throughput: one word per cycle while rsp_bus is ready. The pipe length is set
// by the square root of the squared centre distance (one root bit per stage,
// 17 stages) and the three lane divider for the normal components (one
// quotient bit per stage, 17).
// Each stage holds a valid bit; a stage takes new data whenever it is empty
// or the next stage moves, so bubbles close up and, while a stage is empty,
// requests are still accepted as a finished word waits on a stalled receiver.
// The last stage is the output register. Nothing is lost or repeated under stall.
// Reset (synchronous, active high) empties all stages; no payload is cleared.
module collision_pair_resolver_unit (
   input  logic         clock,
   input  logic         reset,
   cpr_req_if.sink      req_bus,
   cpr_rsp_if.source    rsp_bus
);
   localparam int N = cpr_pkg::NUM_STAGES;
   localparam int C = cpr_pkg::COORD_BITS;

   cpr_pkg::rec_type front;
   cpr_pkg::rec_type stg_ff [N];
   cpr_pkg::rec_type stg_in [N];
   logic [N-1:0]     vld_ff;
   logic [N-1:0]     adv;

   cpr_front u_front (
      .center_a (req_bus.center_a),
      .center_b (req_bus.center_b),
      .extent_a (req_bus.extent_a),
      .extent_b (req_bus.extent_b),
      .radius_a (req_bus.radius_a),
      .radius_b (req_bus.radius_b),
      .flags_a  (req_bus.flags_a),
      .flags_b  (req_bus.flags_b),
      .rec      (front)
   );

   // One stage of work, chosen by position in the pipe.
   function automatic cpr_pkg::rec_type stage_step(input cpr_pkg::rec_type r, input int idx);
      cpr_pkg::rec_type o;
      logic [cpr_pkg::SREM_BITS-1:0]      rt;
      logic [cpr_pkg::SREM_BITS-1:0]      trial;
      logic [cpr_pkg::NUM_BITS-1:0]       sh;
      logic [cpr_pkg::NUM_BITS-1:0]       an;
      logic [cpr_pkg::DIFF_BITS-1:0]      ad;
      logic signed [cpr_pkg::NUM_BITS-1:0] dd;
      logic signed [cpr_pkg::NUM_BITS-1:0] pp;
      logic signed [cpr_pkg::MOVE_BITS-1:0] mv;
      logic [cpr_pkg::SUM_BITS-1:0]       h;
      logic [1:0]                         ax;
      int                                 j;
      int                                 k;
      o = r;
      j = idx - cpr_pkg::ST_SQRT0;
      k = cpr_pkg::ST_OUT - 1 - idx;
      if (idx == cpr_pkg::ST_SQUARE) begin
         // square the magnitude, so the product is a plain unsigned one
         for (int i = 0; i < 3; i++) begin
            ad = r.d[i][cpr_pkg::DIFF_BITS-1] ? -r.d[i] : r.d[i];
            o.sq[i] = cpr_pkg::SQ_BITS'(ad) * cpr_pkg::SQ_BITS'(ad);
         end
         o.rs2 = cpr_pkg::D2_BITS'(r.rs) * cpr_pkg::D2_BITS'(r.rs);
      end else if (idx == cpr_pkg::ST_SUM) begin
         // |d| < 2^16 per axis, so the sum of three squares fits in 34 bits
         o.n = r.sq[0] + r.sq[1] + r.sq[2];
         o.srem = '0;
         o.root = '0;
         if (o.n > r.rs2) begin
            o.mode = cpr_pkg::MV_NONE;
         end else if (r.mode == cpr_pkg::MV_SPHERE && o.n == '0) begin
            o.mode = cpr_pkg::MV_COINCIDENT;
         end
      end else if (idx >= cpr_pkg::ST_SQRT0 && idx < cpr_pkg::ST_PEN) begin
         rt = {r.srem[cpr_pkg::SREM_BITS-3:0], r.n[cpr_pkg::D2_BITS-1-2*j -: 2]};
         trial = cpr_pkg::SREM_BITS'({r.root, 2'b01});
         if (rt >= trial) begin
            o.srem = rt - trial;
            o.root = {r.root[cpr_pkg::SUM_BITS-2:0], 1'b1};
         end else begin
            o.srem = rt;
            o.root = {r.root[cpr_pkg::SUM_BITS-2:0], 1'b0};
         end
      end else if (idx == cpr_pkg::ST_PEN) begin
         o.pen = r.rs - r.root;
         o.dv = {r.root, 1'b0};
      end else if (idx == cpr_pkg::ST_MUL) begin
         pp = cpr_pkg::NUM_BITS'($signed({1'b0, r.pen}));
         for (int i = 0; i < 3; i++) begin
            dd = cpr_pkg::NUM_BITS'($signed(r.d[i]));
            o.num[i] = dd * pp;
         end
      end else if (idx == cpr_pkg::ST_MAG) begin
         for (int i = 0; i < 3; i++) begin
            o.neg[i] = r.num[i][cpr_pkg::NUM_BITS-1];
            an = o.neg[i] ? -r.num[i] : r.num[i];
            o.drem[i] = an + cpr_pkg::NUM_BITS'(r.root);
            o.q[i] = '0;
         end
      end else if (idx >= cpr_pkg::ST_DIV0 && idx < cpr_pkg::ST_OUT) begin
         for (int i = 0; i < 3; i++) begin
            sh = cpr_pkg::NUM_BITS'(r.dv) << k;
            if (r.drem[i] >= sh) begin
               o.drem[i] = r.drem[i] - sh;
               o.q[i][k] = 1'b1;
            end
         end
      end else if (idx == cpr_pkg::ST_OUT) begin
         o.move_a = '0;
         o.move_b = '0;
         // least box overlap, ties to x then y
         if (r.ov[0] <= r.ov[1] && r.ov[0] <= r.ov[2]) begin
            ax = 2'd0;
         end else if (r.ov[1] <= r.ov[2]) begin
            ax = 2'd1;
         end else begin
            ax = 2'd2;
         end
         h = (r.rs + cpr_pkg::SUM_BITS'(1)) >> 1;
         unique case (r.mode)
            cpr_pkg::MV_SPHERE: begin
               for (int i = 0; i < 3; i++) begin
                  mv = $signed(cpr_pkg::MOVE_BITS'(r.q[i]));
                  o.move_a[i*C +: C] = cpr_pkg::sat_coord(r.neg[i] ? -mv : mv);
                  o.move_b[i*C +: C] = cpr_pkg::sat_coord(r.neg[i] ? mv : -mv);
               end
            end
            cpr_pkg::MV_COINCIDENT: begin
               mv = $signed(cpr_pkg::MOVE_BITS'(h));
               o.move_a[C-1:0] = cpr_pkg::sat_coord(mv);
               o.move_b[C-1:0] = cpr_pkg::sat_coord(-mv);
            end
            cpr_pkg::MV_PUSH_A: begin
               // A moves; negative when A lies below B on that axis
               mv = cpr_pkg::MOVE_BITS'(r.ov[ax]);
               if (r.d[ax][cpr_pkg::DIFF_BITS-1]) mv = -mv;
               o.move_a[ax*C +: C] = cpr_pkg::sat_coord(mv);
            end
            cpr_pkg::MV_PUSH_B: begin
               mv = cpr_pkg::MOVE_BITS'(r.ov[ax]);
               if (!r.d[ax][cpr_pkg::DIFF_BITS-1] && r.d[ax] != '0) mv = -mv;
               o.move_b[ax*C +: C] = cpr_pkg::sat_coord(mv);
            end
            default: ;
         endcase
      end
      return o;
   endfunction

   // a stage loads when empty or when its contents move on
   always_comb begin
      adv[N-1] = !vld_ff[N-1] || rsp_bus.ready;
      for (int i = N - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign stg_in[0] = front;
   for (genvar g = 1; g < N; g++) begin : g_stage
      assign stg_in[g] = stage_step(stg_ff[g-1], g);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (adv[i]) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_bus.valid;
         end
         for (int i = 1; i < N; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   assign req_bus.ready      = adv[0];
   assign rsp_bus.valid      = vld_ff[N-1];
   assign rsp_bus.event_kind = stg_ff[N-1].kind;
   assign rsp_bus.move_a     = stg_ff[N-1].move_a;
   assign rsp_bus.move_b     = stg_ff[N-1].move_b;

endmodule

// ===== rtl/cpr_front.sv =====
// Pair classification: deltas, box overlaps, event kind, response mode.
module cpr_front (
   input  logic [cpr_pkg::VEC_BITS-1:0] center_a,
   input  logic [cpr_pkg::VEC_BITS-1:0] center_b,
   input  logic [cpr_pkg::VEC_BITS-1:0] extent_a,
   input  logic [cpr_pkg::VEC_BITS-1:0] extent_b,
   input  logic [15:0]                  radius_a,
   input  logic [15:0]                  radius_b,
   input  logic [1:0]                   flags_a,
   input  logic [1:0]                   flags_b,
   output cpr_pkg::rec_type             rec
);
   localparam int C = cpr_pkg::COORD_BITS;

   logic signed [2:0][cpr_pkg::DIFF_BITS-1:0] d;
   logic signed [2:0][cpr_pkg::OV_BITS-1:0]   ov;
   logic [2:0]                                ov_neg;
   logic                                      overlap;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [cpr_pkg::DIFF_BITS-1:0] ca;
         logic signed [cpr_pkg::DIFF_BITS-1:0] cb;
         logic [cpr_pkg::DIFF_BITS-1:0]        ad;
         logic [cpr_pkg::SUM_BITS-1:0]         es;
         ca = cpr_pkg::DIFF_BITS'($signed(center_a[i*C +: C]));
         cb = cpr_pkg::DIFF_BITS'($signed(center_b[i*C +: C]));
         d[i] = ca - cb;
         ad = d[i][cpr_pkg::DIFF_BITS-1] ? -d[i] : d[i];
         es = cpr_pkg::SUM_BITS'(extent_a[i*C +: C]) + cpr_pkg::SUM_BITS'(extent_b[i*C +: C]);
         ov[i] = $signed(cpr_pkg::OV_BITS'(es)) - $signed(cpr_pkg::OV_BITS'(ad));
         ov_neg[i] = ov[i][cpr_pkg::OV_BITS-1];
      end
      overlap = ~|ov_neg;

      rec = '0;
      rec.d = d;
      rec.ov = ov;
      rec.rs = cpr_pkg::SUM_BITS'(radius_a[C-1:0]) + cpr_pkg::SUM_BITS'(radius_b[C-1:0]);
      priority if (!overlap || (flags_a[0] && flags_b[0])) begin
         rec.kind = cpr_pkg::EV_NONE;
         rec.mode = cpr_pkg::MV_NONE;
      end else if (flags_a[0] || flags_b[0]) begin
         rec.kind = cpr_pkg::EV_TRIGGER;
         rec.mode = cpr_pkg::MV_NONE;
      end else begin
         rec.kind = cpr_pkg::EV_COLLISION;
         unique case (flags_b[1:1] == 1'b1 ? {flags_a[1], 1'b1} : {flags_a[1], 1'b0})
            2'b00:   rec.mode = cpr_pkg::MV_SPHERE;
            2'b01:   rec.mode = cpr_pkg::MV_PUSH_A;
            2'b10:   rec.mode = cpr_pkg::MV_PUSH_B;
            default: rec.mode = cpr_pkg::MV_NONE;
         endcase
      end
   end
endmodule
